FILE: hw/rtl/plt_pkg.sv
// Shared types, constants and action codes for the packed list table.
`default_nettype none
package plt_pkg;

	localparam int DEPTH_DEF     = 64;
	localparam int WORD_BITS_DEF = 32;
	localparam int CAP_W         = 7;
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	typedef enum logic [3:0] {
		ACT_APPEND  = 4'd0,
		ACT_POP     = 4'd1,
		ACT_DELETE  = 4'd2,
		ACT_FIND    = 4'd3,
		ACT_READ    = 4'd4,
		ACT_CLEAR   = 4'd5,
		ACT_DROP    = 4'd6,
		ACT_REVERSE = 4'd7,
		ACT_SORTED  = 4'd8
	} plt_action_t;

	typedef enum logic [4:0] {
		ST_IDLE    = 5'b00001,
		ST_WALK    = 5'b00010,
		ST_REV_WLO = 5'b00100,
		ST_REV_WHI = 5'b01000,
		ST_DONE    = 5'b10000
	} plt_state_t;

	typedef struct packed {
		logic eq;
		logic gt;
	} plt_cmp_t;

endpackage
`default_nettype wire

FILE: hw/rtl/plt_if.sv
// Request and response channel interfaces of the packed list table.
`default_nettype none
interface plt_req_if;
	logic               valid;
	logic               ready;
	logic [3:0]         action;
	logic signed [31:0] value;
	logic [5:0]         index;
	logic [6:0]         count;

	modport source (output valid, action, value, index, count, input ready);
	modport sink (input valid, action, value, index, count, output ready);
endinterface

interface plt_rsp_if;
	logic               valid;
	logic               ready;
	logic               ok;
	logic signed [6:0]  found_index;
	logic signed [31:0] read_value;
	logic [6:0]         occupancy;
	logic               is_empty;
	logic               is_full;

	modport source (output valid, ok, found_index, read_value, occupancy, is_empty, is_full,
		input ready);
	modport sink (input valid, ok, found_index, read_value, occupancy, is_empty, is_full,
		output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/plt_store.sv
// Element memory: one write port and two registered read ports.
`default_nettype none
module plt_store
	import plt_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [AW-1:0]        waddr,
	input  wire logic [WORD_BITS-1:0] wdata,
	input  wire logic                 re,
	input  wire logic [AW-1:0]        raddr_a,
	input  wire logic [AW-1:0]        raddr_b,
	output logic      [WORD_BITS-1:0] rdata_a,
	output logic      [WORD_BITS-1:0] rdata_b
);

	logic [WORD_BITS-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read data holds while re is low, so a swap can write between its reads.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/plt_cmp.sv
// Shared word comparator: equality and signed greater-than.
`default_nettype none
module plt_cmp
	import plt_pkg::*;
#(
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  wire logic [WORD_BITS-1:0] a,
	input  wire logic [WORD_BITS-1:0] b,
	output plt_cmp_t                  res
);

	assign res.eq = (a == b);
	assign res.gt = ($signed(a) > $signed(b));

endmodule
`default_nettype wire

FILE: hw/rtl/packed_list_table_unit.sv
// Packed list table: an order-preserving list of signed words with one result per request.
// Each accepted request yields exactly one response transaction. Append, pop, clear, drop and
// undefined actions go straight to the done state; read at walks its one entry. Find, delete
// and sorted check walk the memory one entry per cycle, find and sorted check testing each in
// the shared comparator (delete starts past its index and moves each entry down, find stops
// at the first match, sorted check at the first descent). Reverse writes the low and then the
// high entry of each pair in its own state, since the memory has a single write port. The
// request channel is ready only between requests; a finished response waits in an output
// register as the next request is accepted and run. The memory needs no clearing after reset.
`default_nettype none
module packed_list_table_unit
	import plt_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [CAP_W-1:0] cfg_wdata,
	plt_req_if.sink               req,
	plt_rsp_if.source             rsp
);

	localparam int AW    = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int XW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	plt_state_t           state_q;
	plt_action_t          act_q;
	logic [CAP_W-1:0]     cap_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [CNT_W-1:0]     ptr_q;
	logic [CNT_W-1:0]     end_q;
	logic [CNT_W-1:0]     addr_s1;
	logic                 vld_s1;
	logic [WORD_BITS-1:0] val_q;
	logic                 ok_q;
	logic signed [6:0]    fidx_q;
	logic signed [31:0]   rdv_q;
	logic                 oval_q;

	logic                 acc;
	logic                 issue;
	logic                 out_free;
	logic                 room;
	logic                 idx_ok;
	logic [CNT_W-1:0]     ptr_nx;
	logic [CNT_W-1:0]     end_dec;
	logic [CNT_W-1:0]     cnt_dec;
	logic [CNT_W-1:0]     addr_dec;
	logic [WORD_BITS-1:0] in_word;

	logic                 we;
	logic [AW-1:0]        waddr;
	logic [WORD_BITS-1:0] wdata;
	logic                 re;
	logic [AW-1:0]        raddr_a;
	logic [AW-1:0]        raddr_b;
	logic [WORD_BITS-1:0] rdata_a;
	logic [WORD_BITS-1:0] rdata_b;
	logic [WORD_BITS-1:0] cmp_b;
	plt_cmp_t             cmp;

	assign acc      = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign out_free = !oval_q || rsp.ready;
	assign room     = (XW'(cnt_q) < XW'(cap_q)) && (cnt_q < CNT_W'(DEPTH));
	assign idx_ok   = (XW'(req.index) < XW'(cnt_q));
	assign ptr_nx   = ptr_q + CNT_W'(1);
	assign end_dec  = end_q - CNT_W'(1);
	assign cnt_dec  = cnt_q - CNT_W'(1);
	assign addr_dec = addr_s1 - CNT_W'(1);
	assign in_word  = WORD_BITS'(req.value);
	assign issue    = (state_q == ST_WALK) && (ptr_q < end_q);

	plt_store #(
		.DEPTH(DEPTH),
		.WORD_BITS(WORD_BITS)
	) u_store (
		.clk(clk),
		.we(we),
		.waddr(waddr),
		.wdata(wdata),
		.re(re),
		.raddr_a(raddr_a),
		.raddr_b(raddr_b),
		.rdata_a(rdata_a),
		.rdata_b(rdata_b)
	);

	assign cmp_b = (act_q == ACT_SORTED) ? rdata_b : val_q;

	plt_cmp #(
		.WORD_BITS(WORD_BITS)
	) u_cmp (
		.a(rdata_a),
		.b(cmp_b),
		.res(cmp)
	);

	// Memory port steering.
	always_comb begin
		we      = 1'b0;
		waddr   = cnt_q[AW-1:0];
		wdata   = in_word;
		re      = 1'b0;
		raddr_a = ptr_q[AW-1:0];
		raddr_b = ptr_nx[AW-1:0];
		unique case (state_q)
			ST_IDLE: begin
				if (acc && req.action == ACT_APPEND && room) begin
					we = 1'b1;
				end
				// A reverse fetches its first pair as it is accepted.
				if (acc && req.action == ACT_REVERSE && cnt_q > CNT_W'(1)) begin
					re      = 1'b1;
					raddr_a = '0;
					raddr_b = cnt_dec[AW-1:0];
				end
			end
			ST_WALK: begin
				re = issue;
				if (vld_s1 && act_q == ACT_DELETE) begin
					we    = 1'b1;
					waddr = addr_dec[AW-1:0];
					wdata = rdata_a;
				end
			end
			ST_REV_WLO: begin
				we    = 1'b1;
				waddr = ptr_q[AW-1:0];
				wdata = rdata_b;
			end
			ST_REV_WHI: begin
				we      = 1'b1;
				waddr   = end_q[AW-1:0];
				wdata   = rdata_a;
				re      = 1'b1;
				raddr_a = ptr_nx[AW-1:0];
				raddr_b = end_dec[AW-1:0];
			end
			ST_DONE: begin
				re = 1'b0;
			end
			default: begin
				re = 1'b0;
			end
		endcase
	end

	// Sequencer and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			act_q   <= ACT_APPEND;
			cap_q   <= CAP_RESET;
			cnt_q   <= '0;
			ptr_q   <= '0;
			end_q   <= '0;
			addr_s1 <= '0;
			vld_s1  <= 1'b0;
			val_q   <= '0;
			ok_q    <= 1'b0;
			fidx_q  <= '1;
			rdv_q   <= '0;
			oval_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (state_q == ST_DONE && out_free) begin
				oval_q <= 1'b1;
			end else if (oval_q && rsp.ready) begin
				oval_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						act_q  <= plt_action_t'(req.action);
						val_q  <= in_word;
						fidx_q <= '1;
						vld_s1 <= 1'b0;
						rdv_q  <= (req.action == ACT_READ && !idx_ok) ? '1 : '0;
						unique case (req.action)
							ACT_APPEND: begin
								ok_q    <= room;
								state_q <= ST_DONE;
								if (room) begin
									cnt_q <= cnt_q + CNT_W'(1);
								end
							end
							ACT_POP: begin
								ok_q    <= (cnt_q != '0);
								state_q <= ST_DONE;
								if (cnt_q != '0) begin
									cnt_q <= cnt_dec;
								end
							end
							ACT_DELETE: begin
								ok_q <= idx_ok;
								if (idx_ok) begin
									cnt_q   <= cnt_dec;
									ptr_q   <= CNT_W'(req.index) + CNT_W'(1);
									end_q   <= cnt_q;
									state_q <= ST_WALK;
								end else begin
									state_q <= ST_DONE;
								end
							end
							ACT_FIND: begin
								ok_q    <= 1'b0;
								ptr_q   <= '0;
								end_q   <= cnt_q;
								state_q <= ST_WALK;
							end
							ACT_READ: begin
								ok_q <= idx_ok;
								if (idx_ok) begin
									ptr_q   <= CNT_W'(req.index);
									end_q   <= CNT_W'(req.index) + CNT_W'(1);
									state_q <= ST_WALK;
								end else begin
									state_q <= ST_DONE;
								end
							end
							ACT_CLEAR: begin
								cnt_q   <= '0;
								ok_q    <= 1'b1;
								state_q <= ST_DONE;
							end
							ACT_DROP: begin
								ok_q    <= 1'b1;
								state_q <= ST_DONE;
								if (XW'(req.count) >= XW'(cnt_q)) begin
									cnt_q <= '0;
								end else begin
									cnt_q <= CNT_W'(XW'(cnt_q) - XW'(req.count));
								end
							end
							ACT_REVERSE: begin
								ok_q <= 1'b1;
								if (cnt_q > CNT_W'(1)) begin
									ptr_q   <= '0;
									end_q   <= cnt_dec;
									state_q <= ST_REV_WLO;
								end else begin
									state_q <= ST_DONE;
								end
							end
							ACT_SORTED: begin
								ok_q <= 1'b1;
								if (cnt_q > CNT_W'(1)) begin
									ptr_q   <= '0;
									end_q   <= cnt_dec;
									state_q <= ST_WALK;
								end else begin
									state_q <= ST_DONE;
								end
							end
							default: begin
								ok_q    <= 1'b0;
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_WALK: begin
					vld_s1  <= issue;
					addr_s1 <= ptr_q;
					if (issue) begin
						ptr_q <= ptr_nx;
					end
					// The entry read last cycle is examined while the next is fetched.
					if (vld_s1 && act_q == ACT_FIND && cmp.eq) begin
						ok_q    <= 1'b1;
						fidx_q  <= 7'(addr_s1);
						state_q <= ST_DONE;
					end else if (vld_s1 && act_q == ACT_SORTED && cmp.gt) begin
						ok_q    <= 1'b0;
						state_q <= ST_DONE;
					end else if (!issue && !vld_s1) begin
						state_q <= ST_DONE;
					end
					if (vld_s1 && act_q == ACT_READ) begin
						rdv_q <= 32'(signed'(rdata_a));
					end
				end
				ST_REV_WLO: begin
					state_q <= ST_REV_WHI;
				end
				ST_REV_WHI: begin
					ptr_q <= ptr_nx;
					end_q <= end_dec;
					if (ptr_nx < end_dec) begin
						state_q <= ST_REV_WLO;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Response payload is captured as the transaction is offered.
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			rsp.ok          <= ok_q;
			rsp.found_index <= fidx_q;
			rsp.read_value  <= rdv_q;
			rsp.occupancy   <= 7'(cnt_q);
			rsp.is_empty    <= (cnt_q == '0);
			rsp.is_full     <= (XW'(cnt_q) >= XW'(cap_q)) || (cnt_q >= CNT_W'(DEPTH));
		end
	end

	assign rsp.valid = oval_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("entry count exceeds store depth");

	a_walk_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && vld_s1) |-> (addr_s1 < end_q))
		else $error("walk examined an entry past its limit");

	a_done_offer: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> (rsp.valid && state_q == ST_IDLE))
		else $error("finished result was not offered");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && req.action == ACT_CLEAR) |=> (cnt_q == '0))
		else $error("clear left entries behind");

endmodule
`default_nettype wire
